/* rtl/core/mcmb_pkg.sv */
`timescale 1ns / 1ps

package mcmb_pkg;

  localparam int unsigned MaxSats  = 64;
  localparam int unsigned MaxSigs  = 32;
  localparam int unsigned MaxCells = 64;

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_FINISH = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_WR,
    ST_SIG_CNT,
    ST_ROW,
    ST_SCAN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic       operation;
    logic [6:0] sat_id;
    logic [5:0] sig_id;
  } in_t;

  typedef struct packed {
    logic [63:0] sat_mask;
    logic [31:0] sig_mask;
    logic [6:0]  sat_count;
    logic [5:0]  sig_count;
    logic [63:0] cell_mask;
    logic [6:0]  cell_count;
    logic        cell_overflow;
  } out_t;

endpackage

/* rtl/core/mcmb_pair_store.sv */
`timescale 1ns / 1ps

module mcmb_pair_store #(
  parameter int unsigned DEPTH = mcmb_pkg::MaxSats,
  parameter int unsigned WIDTH = mcmb_pkg::MaxSigs,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clr_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [WIDTH-1:0] rd_data_q;

  // A row that is not valid reads as zero, so clearing resets only the valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clr_i) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= valid_q[rd_addr_i] ? mem_q[rd_addr_i] : '0;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/core/msm_cell_mask_builder_unit.sv */
`timescale 1ns / 1ps
// An add transaction reads the satellite's row, then writes it back with the signal bit set; an
// add with an id of zero or above the limit is ignored. A finish is taken, counts the seen signals,
// visits each satellite row, scans every signal of each seen row, then loads the result once free.
// One transaction is in work at a time; the result register lets the next one start early.
// Reset clears the seen and cell masks, the presence store valid bits and the result valid flag at once.

module msm_cell_mask_builder_unit #(
  parameter int unsigned MAX_SATS  = mcmb_pkg::MaxSats,
  parameter int unsigned MAX_SIGS  = mcmb_pkg::MaxSigs,
  parameter int unsigned MAX_CELLS = mcmb_pkg::MaxCells
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mcmb_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mcmb_pkg::out_t out_o
);

  localparam int unsigned SatAw = (MAX_SATS > 1) ? $clog2(MAX_SATS) : 1;
  localparam logic [MAX_SIGS-1:0] SigOne = MAX_SIGS'(1);

  mcmb_pkg::state_e state_q, state_d;

  logic [63:0]         seen_sats_q, seen_sats_d;
  logic [31:0]         seen_sigs_q, seen_sigs_d;
  logic [SatAw-1:0]    sat_idx_q, sat_idx_d;
  logic [MAX_SIGS-1:0] sig_oh_q, sig_oh_d;
  logic [5:0]          row_q, row_d;
  logic [4:0]          scan_q, scan_d;
  logic [5:0]          rank_q, rank_d;
  logic [5:0]          nsig_q, nsig_d;
  logic [6:0]          nsat_q, nsat_d;
  logic [11:0]         base_q, base_d;
  logic [63:0]         cells_q, cells_d;
  logic [6:0]          ncell_q, ncell_d;
  logic                out_valid_q, out_valid_d;
  mcmb_pkg::out_t      out_q;

  logic                rd_en;
  logic [SatAw-1:0]    rd_addr;
  logic [MAX_SIGS-1:0] rd_data;
  logic                wr_en;
  logic                clr;
  logic                out_load;

  logic [6:0]  sat_m1;
  logic [5:0]  sig_m1;
  logic        ids_ok;
  logic        last_row;
  logic        last_sig;
  logic [31:0] row_word;
  logic [11:0] pos;

  assign sat_m1   = in_i.sat_id - 7'd1;
  assign sig_m1   = in_i.sig_id - 6'd1;
  assign ids_ok   = (in_i.sat_id != 7'd0) && (in_i.sat_id <= 7'(MAX_SATS)) &&
                    (in_i.sig_id != 6'd0) && (in_i.sig_id <= 6'(MAX_SIGS));
  assign last_row = (row_q == 6'(MAX_SATS - 1));
  assign last_sig = (scan_q == 5'(MAX_SIGS - 1));
  assign row_word = 32'(rd_data);
  assign pos      = base_q + 12'(rank_q);

  mcmb_pair_store #(
    .DEPTH(MAX_SATS),
    .WIDTH(MAX_SIGS)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clr_i    (clr),
    .wr_en_i  (wr_en),
    .wr_addr_i(sat_idx_q),
    .wr_data_i(rd_data | sig_oh_q),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  always_comb begin
    state_d     = state_q;
    seen_sats_d = seen_sats_q;
    seen_sigs_d = seen_sigs_q;
    sat_idx_d   = sat_idx_q;
    sig_oh_d    = sig_oh_q;
    row_d       = row_q;
    scan_d      = scan_q;
    rank_d      = rank_q;
    nsig_d      = nsig_q;
    nsat_d      = nsat_q;
    base_d      = base_q;
    cells_d     = cells_q;
    ncell_d     = ncell_q;
    rd_en       = 1'b0;
    rd_addr     = row_q[SatAw-1:0];
    wr_en       = 1'b0;
    clr         = 1'b0;
    out_load    = 1'b0;

    unique case (state_q)
      mcmb_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (in_i.operation == mcmb_pkg::OP_FINISH) begin
            scan_d  = '0;
            nsig_d  = '0;
            state_d = mcmb_pkg::ST_SIG_CNT;
          end else if (ids_ok) begin
            seen_sats_d[sat_m1[5:0]] = 1'b1;
            seen_sigs_d[sig_m1[4:0]] = 1'b1;
            sat_idx_d = sat_m1[SatAw-1:0];
            sig_oh_d  = SigOne << sig_m1[4:0];
            rd_en     = 1'b1;
            rd_addr   = sat_m1[SatAw-1:0];
            state_d   = mcmb_pkg::ST_ADD_WR;
          end
        end
      end
      mcmb_pkg::ST_ADD_WR: begin
        wr_en   = 1'b1;
        state_d = mcmb_pkg::ST_IDLE;
      end
      mcmb_pkg::ST_SIG_CNT: begin
        nsig_d = nsig_q + 6'(seen_sigs_q[scan_q]);
        if (last_sig) begin
          row_d   = '0;
          base_d  = '0;
          nsat_d  = '0;
          cells_d = '0;
          ncell_d = '0;
          state_d = mcmb_pkg::ST_ROW;
        end else begin
          scan_d = scan_q + 5'd1;
        end
      end
      mcmb_pkg::ST_ROW: begin
        if (seen_sats_q[row_q]) begin
          rd_en   = 1'b1;
          nsat_d  = nsat_q + 7'd1;
          scan_d  = '0;
          rank_d  = '0;
          state_d = mcmb_pkg::ST_SCAN;
        end else if (last_row) begin
          state_d = mcmb_pkg::ST_EMIT;
        end else begin
          row_d = row_q + 6'd1;
        end
      end
      mcmb_pkg::ST_SCAN: begin
        if (seen_sigs_q[scan_q]) begin
          rank_d = rank_q + 6'd1;
          if (row_word[scan_q]) begin
            if (pos < 12'(MAX_CELLS)) begin
              cells_d[pos[5:0]] = 1'b1;
            end
            if (ncell_q < 7'(MAX_CELLS)) begin
              ncell_d = ncell_q + 7'd1;
            end
          end
        end
        if (last_sig) begin
          base_d = base_q + 12'(nsig_q);
          if (last_row) begin
            state_d = mcmb_pkg::ST_EMIT;
          end else begin
            row_d   = row_q + 6'd1;
            state_d = mcmb_pkg::ST_ROW;
          end
        end else begin
          scan_d = scan_q + 5'd1;
        end
      end
      mcmb_pkg::ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          seen_sats_d = '0;
          seen_sigs_d = '0;
          clr         = 1'b1;
          state_d     = mcmb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mcmb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mcmb_pkg::ST_IDLE;
      seen_sats_q <= '0;
      seen_sigs_q <= '0;
      out_valid_q <= 1'b0;
      row_q       <= '0;
      scan_q      <= '0;
      rank_q      <= '0;
      nsig_q      <= '0;
      nsat_q      <= '0;
      base_q      <= '0;
      cells_q     <= '0;
      ncell_q     <= '0;
    end else begin
      state_q     <= state_d;
      seen_sats_q <= seen_sats_d;
      seen_sigs_q <= seen_sigs_d;
      out_valid_q <= out_valid_d;
      row_q       <= row_d;
      scan_q      <= scan_d;
      rank_q      <= rank_d;
      nsig_q      <= nsig_d;
      nsat_q      <= nsat_d;
      base_q      <= base_d;
      cells_q     <= cells_d;
      ncell_q     <= ncell_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sat_idx_q <= sat_idx_d;
    sig_oh_q  <= sig_oh_d;
    if (out_load) begin
      out_q.sat_mask      <= seen_sats_q;
      out_q.sig_mask      <= seen_sigs_q;
      out_q.sat_count     <= nsat_q;
      out_q.sig_count     <= nsig_q;
      out_q.cell_mask     <= cells_q;
      out_q.cell_count    <= ncell_q;
      out_q.cell_overflow <= (base_q > 12'(MAX_CELLS));
    end
  end

  assign in_stall_o  = (state_q != mcmb_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

/* rtl/core/mcmb_checker.sv */
`timescale 1ns / 1ps

module mcmb_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input mcmb_pkg::in_t  in_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input mcmb_pkg::out_t out_o
);

  // A result transaction that is held back keeps its valid and its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("held result changed");

  // An add transaction never yields a result in the next cycle on its own.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_i.operation == mcmb_pkg::OP_ADD) && !out_valid_o
    |=> !out_valid_o)
    else $error("result appeared after an add");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (7'($countones(out_o.sat_mask)) == out_o.sat_count) &&
                    (6'($countones(out_o.sig_mask)) == out_o.sig_count))
    else $error("mask and count disagree");

  // Without overflow every observed cell lies below the cap, so cell mask and cell count agree.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.cell_overflow
    |-> 7'($countones(out_o.cell_mask)) == out_o.cell_count)
    else $error("cell mask and cell count disagree");

endmodule

bind msm_cell_mask_builder_unit mcmb_checker u_mcmb_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_i       (in_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_o      (out_o)
);
